// ----- hw/rtl/oal_pkg.sv -----
// Package for the ordered array list engine.
// Holds the item structs, operation and status codes and sequencer states.
// No dependencies.
package oal_pkg;

    typedef enum logic [1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_UPDATE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_READ,
        SQ_STEP,
        SQ_PLACE,
        SQ_DONE
    } t_seq_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         index;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] found_index;
        logic [7:0] entry_count;
    } t_out_item;

    typedef struct packed {
        t_op                op;
        logic [7:0]         index;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_link;

endpackage

// ----- hw/rtl/oal_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module oal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/oal_front.sv -----
// Front end: accepts items, decodes the operation and holds them in a
// two-entry command queue for the sequencer. Depends on oal_pkg.
module oal_front
    import oal_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_item,
    output logic      o_full,
    output t_cmd_link o_link,
    input  logic      i_take
);

    t_cmd       r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_fill;
    logic       w_push_ok;
    logic       w_take_ok;
    t_cmd       w_cmd;

    assign o_full    = (r_fill == 2'd2);
    assign w_push_ok = i_push && !o_full;
    assign w_take_ok = i_take && (r_fill != 2'd0);

    always_comb begin
        w_cmd.op    = t_op'(i_item.opcode);
        w_cmd.index = i_item.index;
        w_cmd.value = i_item.value;
        n_wr_ptr    = r_wr_ptr ^ w_push_ok;
        n_rd_ptr    = r_rd_ptr ^ w_take_ok;
        n_fill      = r_fill + {1'b0, w_push_ok} - {1'b0, w_take_ok};
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_buf[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    assign o_link.valid = (r_fill != 2'd0);
    assign o_link.cmd   = r_buf[r_rd_ptr];

endmodule

// ----- hw/rtl/oal_back.sv -----
// Back end: sequencer that carries out one command at a time on the entry
// memory and holds the result in a one-item output slot.
// Depends on oal_pkg and oal_ram.
module oal_back
    import oal_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_link i_link,
    output logic      o_take,
    output logic      o_valid,
    output t_out_item o_result,
    input  logic      i_pop
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    t_seq_state         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    t_op                r_op, n_op;
    logic signed [31:0] r_value, n_value;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [AW-1:0]      r_pos, n_pos;
    t_status            r_status, n_status;
    logic [AW-1:0]      r_found, n_found;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [31:0]        w_wdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic [31:0]        w_rdata;
    logic [CMPW-1:0]    w_idx;
    logic [CMPW-1:0]    w_cnt;
    logic [CW-1:0]      w_last;
    logic               w_slot_free;

    oal_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_idx       = CMPW'(i_link.cmd.index);
    assign w_cnt       = CMPW'(r_count);
    assign w_last      = r_count - CW'(1);
    assign w_slot_free = !r_out_valid || i_pop;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_value     = r_value;
        n_ptr       = r_ptr;
        n_pos       = r_pos;
        n_status    = r_status;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        o_take      = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_ptr;
        w_wdata     = w_rdata;
        w_re        = 1'b0;
        w_raddr     = r_ptr;

        unique case (r_state)
            SQ_IDLE: begin
                if (i_link.valid) begin
                    o_take   = 1'b1;
                    n_op     = i_link.cmd.op;
                    n_value  = i_link.cmd.value;
                    n_status = ST_OK;
                    n_found  = '0;
                    unique case (i_link.cmd.op)
                        OP_SEARCH: begin
                            n_status = ST_NOTFOUND;
                            n_ptr    = '0;
                            n_state  = (r_count == '0) ? SQ_DONE : SQ_READ;
                        end
                        OP_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = SQ_DONE;
                            end else begin
                                n_ptr = AW'(r_count);
                                n_pos = (w_idx >= w_cnt) ? AW'(r_count) : AW'(w_idx);
                                n_state = ((w_idx >= w_cnt) || (AW'(w_idx) == AW'(r_count)))
                                          ? SQ_PLACE : SQ_READ;
                            end
                        end
                        OP_DELETE: begin
                            if (w_idx >= w_cnt) begin
                                n_status = ST_RANGE;
                                n_state  = SQ_DONE;
                            end else begin
                                n_ptr   = AW'(w_idx);
                                n_state = (CW'(w_idx) == w_last) ? SQ_DONE : SQ_READ;
                            end
                        end
                        OP_UPDATE: begin
                            if (w_idx >= w_cnt) begin
                                n_status = ST_RANGE;
                                n_state  = SQ_DONE;
                            end else begin
                                n_ptr   = AW'(w_idx);
                                n_state = SQ_PLACE;
                            end
                        end
                    endcase
                end
            end
            SQ_READ: begin
                w_re = 1'b1;
                unique case (r_op)
                    OP_INSERT: w_raddr = r_ptr - AW'(1);
                    OP_DELETE: w_raddr = r_ptr + AW'(1);
                    OP_SEARCH,
                    OP_UPDATE: w_raddr = r_ptr;
                endcase
                n_state = SQ_STEP;
            end
            SQ_STEP: begin
                unique case (r_op)
                    OP_SEARCH: begin
                        if (w_rdata == r_value) begin
                            n_status = ST_OK;
                            n_found  = r_ptr;
                            n_state  = SQ_DONE;
                        end else if (CW'(r_ptr) == w_last) begin
                            n_state = SQ_DONE;
                        end else begin
                            n_ptr   = r_ptr + AW'(1);
                            n_state = SQ_READ;
                        end
                    end
                    OP_INSERT: begin
                        w_we    = 1'b1;
                        n_ptr   = r_ptr - AW'(1);
                        n_state = ((r_ptr - AW'(1)) == r_pos) ? SQ_PLACE : SQ_READ;
                    end
                    OP_DELETE: begin
                        w_we    = 1'b1;
                        n_ptr   = r_ptr + AW'(1);
                        n_state = ((CW'(r_ptr) + CW'(1)) == w_last) ? SQ_DONE : SQ_READ;
                    end
                    OP_UPDATE: begin
                        n_state = SQ_PLACE;
                    end
                endcase
            end
            SQ_PLACE: begin
                w_we    = 1'b1;
                w_wdata = r_value;
                n_state = SQ_DONE;
            end
            SQ_DONE: begin
                if (w_slot_free) begin
                    if (r_status == ST_OK && r_op == OP_INSERT) begin
                        n_count = r_count + CW'(1);
                    end else if (r_status == ST_OK && r_op == OP_DELETE) begin
                        n_count = r_count - CW'(1);
                    end
                    n_out.status      = r_status;
                    n_out.found_index = 7'(r_found);
                    n_out.entry_count = 8'(n_count);
                    n_out_valid       = 1'b1;
                    n_state           = SQ_IDLE;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_value  <= n_value;
        r_ptr    <= n_ptr;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_found  <= n_found;
        r_out    <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- hw/rtl/ordered_array_list_engine_core.sv -----
// Ordered array list engine, top level.
// Instantiates oal_front and oal_back; depends on oal_pkg.
//
// Usage:
// Items enter through a queue interface: an item is taken at a clock edge
// with push high and full low. Each item is an opcode (search, insert,
// delete, update), an index and a signed 32-bit value. Each item gives one
// result, read through a queue interface: while empty is low the oldest
// result is on o_out_item, and pop with empty low takes it. A result holds
// a status, the index of a search hit and the entry count after the item.
// Items are held in a two-entry command queue and carried out one at a
// time by a sequencer on a two-port entry memory with registered read.
// Each entry compared or moved takes a read step, then a compare or write
// step: search reads from index 0 up to a hit or the last entry, insert
// moves entries from the end down to the index and writes the value,
// delete moves entries above the index down, and update writes in place.
// After reset the list is empty and no result waits. While the receiver
// does not pop, one finished result is held and the sequencer waits on the
// next one; the command queue keeps taking items until it is full.
module ordered_array_list_engine_core
    import oal_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    t_cmd_link w_link;
    logic      w_take;
    logic      w_valid;

    oal_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_item),
        .o_full  (full),
        .o_link  (w_link),
        .i_take  (w_take)
    );

    oal_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_link   (w_link),
        .o_take   (w_take),
        .o_valid  (w_valid),
        .o_result (o_out_item),
        .i_pop    (pop)
    );

    assign empty = !w_valid;

`ifndef SYNTHESIS
    a_found_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.status != ST_OK) |-> (o_out_item.found_index == 7'd0))
        else $error("Nonzero found index on a result that is not a search hit.");

    a_full_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.status == ST_FULL) |-> (o_out_item.entry_count == 8'(CAPACITY)))
        else $error("List reported full below capacity.");

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_link.valid)
        else $error("Sequencer took a command from an empty queue.");
`endif

endmodule
